// ----- rtl/tcs_pkg.sv -----
// Package: shared types, constants and codes of the TCP connection block.
`timescale 1ns / 1ps
package tcs_pkg;

  localparam int unsigned MssW = 11;
  localparam int unsigned WinW = 16;
  localparam int unsigned SeqW = 32;
  localparam int unsigned LenW = 15;

  localparam logic [MssW-1:0] MssReset = 11'd1460;
  localparam logic [WinW-1:0] RxCapReset = 16'd8192;
  localparam logic [WinW-1:0] InitWinReset = 16'd65535;
  localparam logic [MssW-1:0] MssMin = 11'd536;
  localparam logic [MssW-1:0] MssMax = 11'd1460;
  localparam logic [LenW-1:0] SendMax = 15'd16384;

  localparam int unsigned QueueDepth = 2;

  localparam logic [5:0] FlFin = 6'h01;
  localparam logic [5:0] FlSyn = 6'h02;
  localparam logic [5:0] FlRst = 6'h04;
  localparam logic [5:0] FlPsh = 6'h08;
  localparam logic [5:0] FlAck = 6'h10;

  localparam logic [1:0] CfgMss = 2'd0;
  localparam logic [1:0] CfgRxCap = 2'd1;
  localparam logic [1:0] CfgInitWin = 2'd2;

  typedef enum logic [2:0] {
    CmdSegment = 3'd0,
    CmdOpen = 3'd1,
    CmdClose = 3'd2,
    CmdSend = 3'd3,
    CmdConsume = 3'd4
  } cmd_e;

  localparam logic [3:0] StClosed = 4'd0;
  localparam logic [3:0] StSynSent = 4'd2;
  localparam logic [3:0] StEstab = 4'd4;
  localparam logic [3:0] StFw1 = 4'd5;
  localparam logic [3:0] StFw2 = 4'd6;
  localparam logic [3:0] StClosing = 4'd7;
  localparam logic [3:0] StTimeWait = 4'd8;
  localparam logic [3:0] StCloseWait = 4'd9;
  localparam logic [3:0] StLastAck = 4'd10;

  localparam logic [1:0] StatDone = 2'd0;
  localparam logic [1:0] StatReject = 2'd1;
  localparam logic [1:0] StatIgnored = 2'd2;

  // Classified event handed from the front end to the back end.
  typedef struct packed {
    logic            bad_cmd;
    logic [2:0]      cmd;
    logic            is_fin;
    logic            is_syn;
    logic            is_rst;
    logic            is_ack;
    logic [SeqW-1:0] seg_seq;
    logic [SeqW-1:0] seg_ack;
    logic [WinW-1:0] seg_window;
    logic [LenW-1:0] length;
    logic            checksum_ok;
    logic [SeqW-1:0] start_seq;
  } event_t;

  typedef struct packed {
    logic            emit;
    logic [5:0]      tx_flags;
    logic [SeqW-1:0] tx_seq;
    logic [SeqW-1:0] tx_ack;
    logic [WinW-1:0] tx_window;
    logic [MssW-1:0] tx_length;
    logic [3:0]      conn_state;
    logic [1:0]      status;
    logic [LenW-1:0] byte_count;
    logic            last;
  } result_t;

endpackage

// ----- rtl/tcs_front.sv -----
// Front end: accepts input items, classifies them and queues events.
`timescale 1ns / 1ps
module tcs_front #(
  parameter int unsigned Depth = tcs_pkg::QueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [2:0]            cmd_i,
  input  logic [5:0]            seg_flags_i,
  input  logic [31:0]           seg_seq_i,
  input  logic [31:0]           seg_ack_i,
  input  logic [15:0]           seg_window_i,
  input  logic [14:0]           length_i,
  input  logic                  checksum_ok_i,
  input  logic [31:0]           start_seq_i,
  output logic                  ev_valid_o,
  output tcs_pkg::event_t       ev_o,
  input  logic                  ev_take_i
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  tcs_pkg::event_t q_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  tcs_pkg::event_t ev_in;
  logic            do_push;

  always_comb begin
    ev_in.bad_cmd     = (cmd_i > 3'(tcs_pkg::CmdConsume));
    ev_in.cmd         = cmd_i;
    ev_in.is_fin      = |(seg_flags_i & tcs_pkg::FlFin);
    ev_in.is_syn      = |(seg_flags_i & tcs_pkg::FlSyn);
    ev_in.is_rst      = |(seg_flags_i & tcs_pkg::FlRst);
    ev_in.is_ack      = |(seg_flags_i & tcs_pkg::FlAck);
    ev_in.seg_seq     = seg_seq_i;
    ev_in.seg_ack     = seg_ack_i;
    ev_in.seg_window  = seg_window_i;
    ev_in.length      = length_i;
    ev_in.checksum_ok = checksum_ok_i;
    ev_in.start_seq   = start_seq_i;
  end

  assign full_o     = (cnt_q == (PtrW+1)'(Depth));
  assign do_push    = push_i && !full_o;
  assign ev_valid_o = (cnt_q != '0);
  assign ev_o       = q_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_q[wr_q] <= ev_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (ev_take_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(ev_take_i);
    end
  end

`ifndef SYNTHESIS
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_take_i |-> ev_valid_o) else $error("event taken from empty queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(Depth)) else $error("event queue overflow");
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !ev_take_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("event queue count did not advance");
`endif
endmodule

// ----- rtl/tcs_back.sv -----
// Back end: connection state, event execution and result register.
`timescale 1ns / 1ps
module tcs_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 ev_valid_i,
  input  tcs_pkg::event_t      ev_i,
  output logic                 ev_take_o,
  output logic                 res_valid_o,
  output tcs_pkg::result_t     res_o,
  input  logic                 res_take_i
);
  typedef enum logic [1:0] {
    SIdle,
    SSend
  } state_e;

  state_e state_q;
  logic [10:0] mss_q;
  logic [15:0] rxcap_q, initwin_q;
  logic [3:0]  cs_q;
  logic [31:0] sseq_q, sack_q, rseq_q, hack_q;
  logic [15:0] rxcnt_q, lwin_q, rwin_q;
  logic [14:0] left_q, count_q;
  logic        res_valid_q;
  tcs_pkg::result_t res_q;

  // fin_ack marks a segment that both acked data and carried FIN: the data
  // ack goes out first, then the FIN ack; handled by a detour through pend_q.
  logic        pend_q;
  logic [31:0] pend_ack_q;

  logic [10:0] mss_c;
  logic        slot_free;
  logic        res_load;

  // Combinational single-event outcome.
  logic [3:0]  cs_n;
  logic [31:0] sseq_n, sack_n, rseq_n, hack_n;
  logic [15:0] rxcnt_n, lwin_n, rwin_n;
  logic        emit_n;
  logic [5:0]  fl_n;
  logic [1:0]  stat_n;
  logic [14:0] cnt_n;
  logic        go_send;
  logic        fin_ack;
  logic [16:0] rx_sum;
  logic [14:0] take;
  logic [10:0] seg_len;
  logic        seg_last;

  assign mss_c = (mss_q < tcs_pkg::MssMin) ? tcs_pkg::MssMin :
                 (mss_q > tcs_pkg::MssMax) ? tcs_pkg::MssMax : mss_q;
  assign slot_free = !res_valid_q || res_take_i;
  assign res_valid_o = res_valid_q;
  assign res_o = res_q;
  // Hold the next event while the second ack of a data+FIN segment waits.
  assign ev_take_o = (state_q == SIdle) && !pend_q && ev_valid_i && slot_free;
  assign res_load = ((state_q == SIdle) && pend_q && slot_free) ||
                    (ev_take_o && !go_send) ||
                    ((state_q == SSend) && slot_free);

  assign rx_sum = {1'b0, rxcnt_q} + 17'(ev_i.length);
  assign take = (17'(ev_i.length) < 17'(rxcnt_q)) ? ev_i.length : rxcnt_q[14:0];
  assign seg_last = (left_q <= 15'(mss_c));
  assign seg_len = seg_last ? left_q[10:0] : mss_c;

  always_comb begin
    cs_n = cs_q; sseq_n = sseq_q; sack_n = sack_q; rseq_n = rseq_q;
    hack_n = hack_q; rxcnt_n = rxcnt_q; lwin_n = lwin_q; rwin_n = rwin_q;
    emit_n = 1'b0; fl_n = '0; stat_n = tcs_pkg::StatDone; cnt_n = '0;
    go_send = 1'b0; fin_ack = 1'b0;
    case (ev_i.cmd)
      3'(tcs_pkg::CmdSegment): begin
        if (cs_q == tcs_pkg::StClosed || !ev_i.checksum_ok) begin
          stat_n = tcs_pkg::StatIgnored;
        end else begin
          rwin_n = ev_i.seg_window;
          case (cs_q)
            tcs_pkg::StSynSent: begin
              if (ev_i.is_syn && ev_i.is_ack) begin
                if (ev_i.seg_ack == sseq_q) begin
                  cs_n = tcs_pkg::StEstab;
                  sack_n = ev_i.seg_seq + 32'd1;
                  rseq_n = ev_i.seg_seq + 32'd1;
                  emit_n = 1'b1; fl_n = tcs_pkg::FlAck;
                end
              end else if (ev_i.is_rst) begin
                cs_n = tcs_pkg::StClosed;
              end
            end
            tcs_pkg::StEstab: begin
              // Data and FIN on one segment: two ACKs go out in order, the data ack
              // first; the FIN ack is the later one.
              if (ev_i.length != '0 && ev_i.seg_seq == rseq_q &&
                  rx_sum <= {1'b0, rxcap_q}) begin
                rxcnt_n = rx_sum[15:0];
                rseq_n = rseq_q + 32'(ev_i.length);
                sack_n = rseq_n;
                lwin_n = lwin_q - 16'(ev_i.length);
                emit_n = 1'b1; fl_n = tcs_pkg::FlAck;
              end
              if (ev_i.is_ack && ev_i.seg_ack > hack_q) hack_n = ev_i.seg_ack;
              if (ev_i.is_fin) begin
                cs_n = tcs_pkg::StCloseWait;
                fin_ack = emit_n;
                rseq_n = rseq_n + 32'd1;
                sack_n = rseq_n;
                emit_n = 1'b1; fl_n = tcs_pkg::FlAck;
              end
              if (ev_i.is_rst) cs_n = tcs_pkg::StClosed;
            end
            tcs_pkg::StFw1: begin
              if (ev_i.is_ack && ev_i.seg_ack == sseq_q) cs_n = tcs_pkg::StFw2;
              if (ev_i.is_fin) begin
                rseq_n = rseq_q + 32'd1; sack_n = rseq_n;
                emit_n = 1'b1; fl_n = tcs_pkg::FlAck;
                cs_n = (cs_n == tcs_pkg::StFw2) ? tcs_pkg::StTimeWait
                                                 : tcs_pkg::StClosing;
              end
            end
            tcs_pkg::StFw2: begin
              if (ev_i.is_fin) begin
                rseq_n = rseq_q + 32'd1; sack_n = rseq_n;
                emit_n = 1'b1; fl_n = tcs_pkg::FlAck;
                cs_n = tcs_pkg::StTimeWait;
              end
            end
            tcs_pkg::StLastAck: begin
              if (ev_i.is_ack && ev_i.seg_ack == sseq_q) cs_n = tcs_pkg::StClosed;
            end
            tcs_pkg::StClosing: begin
              if (ev_i.is_ack && ev_i.seg_ack == sseq_q) cs_n = tcs_pkg::StTimeWait;
            end
            default: ;
          endcase
        end
      end
      3'(tcs_pkg::CmdOpen): begin
        if (cs_q != tcs_pkg::StClosed) begin
          stat_n = tcs_pkg::StatReject;
        end else begin
          lwin_n = initwin_q; rwin_n = initwin_q; rxcnt_n = '0;
          hack_n = '0; rseq_n = '0; sack_n = '0;
          sseq_n = ev_i.start_seq;
          cs_n = tcs_pkg::StSynSent;
          emit_n = 1'b1; fl_n = tcs_pkg::FlSyn;
        end
      end
      3'(tcs_pkg::CmdClose): begin
        if (cs_q == tcs_pkg::StClosed) begin
          stat_n = tcs_pkg::StatReject;
        end else if (cs_q == tcs_pkg::StEstab || cs_q == tcs_pkg::StCloseWait) begin
          emit_n = 1'b1; fl_n = tcs_pkg::FlFin | tcs_pkg::FlAck;
          cs_n = (cs_q == tcs_pkg::StEstab) ? tcs_pkg::StFw1 : tcs_pkg::StLastAck;
        end else begin
          cs_n = tcs_pkg::StClosed;
        end
      end
      3'(tcs_pkg::CmdSend): begin
        if (cs_q != tcs_pkg::StEstab || ev_i.length == '0 ||
            ev_i.length > tcs_pkg::SendMax || 16'(ev_i.length) > rwin_q) begin
          stat_n = tcs_pkg::StatReject;
        end else begin
          go_send = 1'b1;
        end
      end
      3'(tcs_pkg::CmdConsume): begin
        if (cs_q != tcs_pkg::StEstab || ev_i.length == '0) begin
          stat_n = tcs_pkg::StatReject;
        end else begin
          rxcnt_n = rxcnt_q - 16'(take);
          lwin_n = lwin_q + 16'(take);
          cnt_n = take;
        end
      end
      default: stat_n = tcs_pkg::StatReject;
    endcase
    if (ev_i.bad_cmd) stat_n = tcs_pkg::StatReject;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && ev_take_o) begin
      left_q  <= ev_i.length;
      count_q <= ev_i.length;
    end else if (state_q == SSend && slot_free) begin
      left_q <= left_q - 15'(seg_len);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      mss_q <= tcs_pkg::MssReset; rxcap_q <= tcs_pkg::RxCapReset;
      initwin_q <= tcs_pkg::InitWinReset;
      cs_q <= tcs_pkg::StClosed;
      sseq_q <= '0; sack_q <= '0; rseq_q <= '0; hack_q <= '0;
      rxcnt_q <= '0; lwin_q <= '0; rwin_q <= '0;
      res_valid_q <= 1'b0; res_q <= '0;
      pend_q <= 1'b0; pend_ack_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tcs_pkg::CfgMss:     mss_q <= cfg_data_i[10:0];
          tcs_pkg::CfgRxCap:   rxcap_q <= cfg_data_i;
          tcs_pkg::CfgInitWin: initwin_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_take_i) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        SIdle: begin
          if (pend_q && slot_free) begin
            // Second ack of a data+FIN segment.
            pend_q <= 1'b0;
            res_q.emit <= 1'b1; res_q.tx_flags <= tcs_pkg::FlAck;
            res_q.tx_seq <= sseq_q; res_q.tx_ack <= pend_ack_q;
            res_q.tx_window <= lwin_q; res_q.tx_length <= '0;
            res_q.last <= 1'b1;
          end else if (ev_take_o) begin
            cs_q <= cs_n; sseq_q <= sseq_n + (fl_n == tcs_pkg::FlSyn ? 32'd1 : 32'd0)
                   + ((fl_n == (tcs_pkg::FlFin | tcs_pkg::FlAck)) ? 32'd1 : 32'd0);
            sack_q <= sack_n; rseq_q <= rseq_n; hack_q <= hack_n;
            rxcnt_q <= rxcnt_n; lwin_q <= lwin_n; rwin_q <= rwin_n;
            res_q.conn_state <= cs_n; res_q.status <= stat_n;
            if (go_send) begin
              state_q <= SSend;
            end else begin
              res_q.emit <= emit_n;
              res_q.tx_flags <= emit_n ? fl_n : 6'd0;
              res_q.tx_seq <= emit_n ? sseq_n : 32'd0;
              res_q.tx_ack <= emit_n ? (fin_ack ? ev_i.seg_seq + 32'(ev_i.length)
                                                : sack_n) : 32'd0;
              res_q.tx_window <= emit_n ? (fin_ack ? lwin_n : lwin_n) : 16'd0;
              res_q.tx_length <= '0;
              res_q.byte_count <= cnt_n;
              res_q.last <= !fin_ack;
              pend_q <= fin_ack;
              pend_ack_q <= sack_n;
            end
          end
        end
        SSend: begin
          if (slot_free) begin
            res_q.emit <= 1'b1; res_q.tx_flags <= tcs_pkg::FlPsh | tcs_pkg::FlAck;
            res_q.tx_seq <= sseq_q; res_q.tx_ack <= sack_q;
            res_q.tx_window <= lwin_q; res_q.tx_length <= seg_len;
            res_q.byte_count <= count_q; res_q.last <= seg_last;
            sseq_q <= sseq_q + 32'(seg_len);
            rwin_q <= rwin_q - 16'(seg_len);
            if (seg_last) state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_take_o |-> (state_q == SIdle)) else $error("event taken while sending");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_take_i) |=> (res_valid_q && $stable(res_q)))
    else $error("result overwritten");
  a_send_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SSend) |-> (left_q != '0)) else $error("send with no bytes left");
`endif
endmodule

// ----- rtl/tcp_connection_state_machine.sv -----
// Top level: TCP connection state machine, queue-style ports.
// An accepted event waits in the event queue and its result is loaded into the
// back end's result register; a send or a full result register holds it back.
// Throughput: one event per cycle while results are popped at once and no send
// or FIN ack is pending; a send gives one result per MSS segment.
// A data segment that also carries FIN gives two results, the data ack first.
// Reset (rst_ni low, asynchronous) closes the connection and loads defaults.
`timescale 1ns / 1ps
module tcp_connection_state_machine #(
  parameter int unsigned QueueDepth = tcs_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  cmd_i,
  input  logic [5:0]  seg_flags_i,
  input  logic [31:0] seg_seq_i,
  input  logic [31:0] seg_ack_i,
  input  logic [15:0] seg_window_i,
  input  logic [14:0] length_i,
  input  logic        checksum_ok_i,
  input  logic [31:0] start_seq_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output logic        empty,
  input  logic        pop,
  output logic        emit_o,
  output logic [5:0]  tx_flags_o,
  output logic [31:0] tx_seq_o,
  output logic [31:0] tx_ack_o,
  output logic [15:0] tx_window_o,
  output logic [10:0] tx_length_o,
  output logic [3:0]  conn_state_o,
  output logic [1:0]  status_o,
  output logic [14:0] byte_count_o,
  output logic        last_o
);
  logic             ev_valid, ev_take, res_valid;
  tcs_pkg::event_t  ev;
  tcs_pkg::result_t res;

  tcs_front #(.Depth(QueueDepth)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full),
    .cmd_i, .seg_flags_i, .seg_seq_i, .seg_ack_i, .seg_window_i,
    .length_i, .checksum_ok_i, .start_seq_i,
    .ev_valid_o(ev_valid), .ev_o(ev), .ev_take_i(ev_take)
  );

  tcs_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .ev_valid_i(ev_valid), .ev_i(ev), .ev_take_o(ev_take),
    .res_valid_o(res_valid), .res_o(res), .res_take_i(pop && res_valid)
  );

  assign empty        = !res_valid;
  assign emit_o       = res.emit;
  assign tx_flags_o   = res.tx_flags;
  assign tx_seq_o     = res.tx_seq;
  assign tx_ack_o     = res.tx_ack;
  assign tx_window_o  = res.tx_window;
  assign tx_length_o  = res.tx_length;
  assign conn_state_o = res.conn_state;
  assign status_o     = res.status;
  assign byte_count_o = res.byte_count;
  assign last_o       = res.last;
endmodule

// ----- bench/tcp_connection_state_machine_tb.sv -----
// Testbench: self-checking stimulus and result checks for the TCP connection block.
`timescale 1ns / 1ps
module tcp_connection_state_machine_tb;

  localparam int unsigned IdleLimit = 4000;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [2:0]  cmd_i;
  logic [5:0]  seg_flags_i;
  logic [31:0] seg_seq_i;
  logic [31:0] seg_ack_i;
  logic [15:0] seg_window_i;
  logic [14:0] length_i;
  logic        checksum_ok_i;
  logic [31:0] start_seq_i;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        empty;
  logic        pop;
  logic        emit_o;
  logic [5:0]  tx_flags_o;
  logic [31:0] tx_seq_o;
  logic [31:0] tx_ack_o;
  logic [15:0] tx_window_o;
  logic [10:0] tx_length_o;
  logic [3:0]  conn_state_o;
  logic [1:0]  status_o;
  logic [14:0] byte_count_o;
  logic        last_o;

  tcp_connection_state_machine i_dut (.*);

  // connection model
  logic [3:0]  conn_st;
  logic [31:0] snd_nxt, ack_out, rcv_nxt, top_ack;
  logic [15:0] rx_bytes, lwin, rwin;
  logic [10:0] cfg_mss;
  logic [15:0] cfg_cap, cfg_iwin;

  tcs_pkg::result_t segs_out[$];
  tcs_pkg::result_t pending_results[$];
  bit      failed;
  bit      hold_req;
  int      burst_left;
  int      idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic put_seg(input logic [5:0] flags, input logic [10:0] len);
    tcs_pkg::result_t r;
    r = '0;
    r.emit = 1'b1;
    r.tx_flags = flags;
    r.tx_seq = snd_nxt;
    r.tx_ack = ack_out;
    r.tx_window = lwin;
    r.tx_length = len;
    segs_out.push_back(r);
    snd_nxt = snd_nxt + len +
              (((flags & (tcs_pkg::FlSyn | tcs_pkg::FlFin)) != 0) ? 1 : 0);
  endtask

  task automatic model_segment(input logic [5:0] fl, input logic [31:0] sq,
                               input logic [31:0] ak, input logic [15:0] win,
                               input logic [14:0] len, input logic ck,
                               output logic [1:0] stat);
    logic [3:0] st;
    st = conn_st;
    stat = tcs_pkg::StatDone;
    if (st == tcs_pkg::StClosed || !ck) begin
      stat = tcs_pkg::StatIgnored;
      return;
    end
    rwin = win;
    case (st)
      tcs_pkg::StSynSent: begin
        if ((fl & (tcs_pkg::FlSyn | tcs_pkg::FlAck)) == (tcs_pkg::FlSyn | tcs_pkg::FlAck)) begin
          if (ak == snd_nxt) begin
            conn_st = tcs_pkg::StEstab;
            ack_out = sq + 1;
            rcv_nxt = sq + 1;
            put_seg(tcs_pkg::FlAck, '0);
          end
        end else if (fl & tcs_pkg::FlRst) begin
          conn_st = tcs_pkg::StClosed;
        end
      end
      tcs_pkg::StEstab: begin
        if (len > 0 && sq == rcv_nxt && 32'(rx_bytes) + 32'(len) <= 32'(cfg_cap)) begin
          rx_bytes = rx_bytes + 16'(len);
          rcv_nxt = rcv_nxt + len;
          ack_out = rcv_nxt;
          lwin = lwin - 16'(len);
          put_seg(tcs_pkg::FlAck, '0);
        end
        if ((fl & tcs_pkg::FlAck) && ak > top_ack) top_ack = ak;
        if (fl & tcs_pkg::FlFin) begin
          conn_st = tcs_pkg::StCloseWait;
          rcv_nxt = rcv_nxt + 1;
          ack_out = rcv_nxt;
          put_seg(tcs_pkg::FlAck, '0);
        end
        if (fl & tcs_pkg::FlRst) conn_st = tcs_pkg::StClosed;
      end
      tcs_pkg::StFw1: begin
        if ((fl & tcs_pkg::FlAck) && ak == snd_nxt) conn_st = tcs_pkg::StFw2;
        if (fl & tcs_pkg::FlFin) begin
          rcv_nxt = rcv_nxt + 1;
          ack_out = rcv_nxt;
          put_seg(tcs_pkg::FlAck, '0);
          conn_st = (conn_st == tcs_pkg::StFw2) ? tcs_pkg::StTimeWait : tcs_pkg::StClosing;
        end
      end
      tcs_pkg::StFw2: begin
        if (fl & tcs_pkg::FlFin) begin
          rcv_nxt = rcv_nxt + 1;
          ack_out = rcv_nxt;
          put_seg(tcs_pkg::FlAck, '0);
          conn_st = tcs_pkg::StTimeWait;
        end
      end
      tcs_pkg::StLastAck:
        if ((fl & tcs_pkg::FlAck) && ak == snd_nxt) conn_st = tcs_pkg::StClosed;
      tcs_pkg::StClosing:
        if ((fl & tcs_pkg::FlAck) && ak == snd_nxt) conn_st = tcs_pkg::StTimeWait;
      default: ;
    endcase
  endtask

  // Work out the results of one accepted item and queue them.
  task automatic model_event(input logic [2:0] c, input logic [5:0] fl,
                             input logic [31:0] sq, input logic [31:0] ak,
                             input logic [15:0] win, input logic [14:0] len,
                             input logic ck, input logic [31:0] ss);
    logic [1:0]  stat;
    logic [14:0] cnt;
    logic [14:0] left, seg, mss, take;
    tcs_pkg::result_t r;
    stat = tcs_pkg::StatDone;
    cnt = '0;
    segs_out.delete();
    case (c)
      tcs_pkg::CmdSegment: model_segment(fl, sq, ak, win, len, ck, stat);
      tcs_pkg::CmdOpen: begin
        if (conn_st != tcs_pkg::StClosed) begin
          stat = tcs_pkg::StatReject;
        end else begin
          lwin = cfg_iwin;
          rwin = cfg_iwin;
          rx_bytes = '0;
          top_ack = '0;
          rcv_nxt = '0;
          ack_out = '0;
          snd_nxt = ss;
          conn_st = tcs_pkg::StSynSent;
          put_seg(tcs_pkg::FlSyn, '0);
        end
      end
      tcs_pkg::CmdClose: begin
        if (conn_st == tcs_pkg::StClosed) begin
          stat = tcs_pkg::StatReject;
        end else if (conn_st == tcs_pkg::StEstab || conn_st == tcs_pkg::StCloseWait) begin
          put_seg(tcs_pkg::FlFin | tcs_pkg::FlAck, '0);
          conn_st = (conn_st == tcs_pkg::StEstab) ? tcs_pkg::StFw1 : tcs_pkg::StLastAck;
        end else begin
          conn_st = tcs_pkg::StClosed;
        end
      end
      tcs_pkg::CmdSend: begin
        if (conn_st != tcs_pkg::StEstab || len == 0 || len > tcs_pkg::SendMax ||
            32'(len) > 32'(rwin)) begin
          stat = tcs_pkg::StatReject;
        end else begin
          mss = 15'(cfg_mss);
          if (mss < 15'(tcs_pkg::MssMin)) mss = 15'(tcs_pkg::MssMin);
          if (mss > 15'(tcs_pkg::MssMax)) mss = 15'(tcs_pkg::MssMax);
          left = len;
          while (left > 0) begin
            seg = (left > mss) ? mss : left;
            put_seg(tcs_pkg::FlPsh | tcs_pkg::FlAck, 11'(seg));
            rwin = rwin - 16'(seg);
            left = left - seg;
          end
          cnt = len;
        end
      end
      tcs_pkg::CmdConsume: begin
        if (conn_st != tcs_pkg::StEstab || len == 0) begin
          stat = tcs_pkg::StatReject;
        end else begin
          take = (32'(len) < 32'(rx_bytes)) ? len : 15'(rx_bytes);
          rx_bytes = rx_bytes - 16'(take);
          lwin = lwin + 16'(take);
          cnt = take;
        end
      end
      default: stat = tcs_pkg::StatReject;
    endcase
    if (segs_out.size() == 0) segs_out.push_back('0);
    foreach (segs_out[k]) begin
      r = segs_out[k];
      r.conn_state = conn_st;
      r.status = stat;
      r.byte_count = cnt;
      r.last = (k == segs_out.size() - 1);
      pending_results.push_back(r);
    end
  endtask

  // Offer one item; returns at the edge that accepts it, push still high.
  task automatic send_item(input logic [2:0] c, input logic [5:0] fl,
                           input logic [31:0] sq, input logic [31:0] ak,
                           input logic [15:0] win, input logic [14:0] len,
                           input logic ck, input logic [31:0] ss);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    push <= 1'b1;
    cmd_i <= c;
    seg_flags_i <= fl;
    seg_seq_i <= sq;
    seg_ack_i <= ak;
    seg_window_i <= win;
    length_i <= len;
    checksum_ok_i <= ck;
    start_seq_i <= ss;
    do @(posedge clk_i); while (full);
    model_event(c, fl, sq, ak, win, len, ck, ss);
  endtask

  task automatic seg_in(input logic [5:0] fl, input logic [31:0] sq, input logic [31:0] ak,
                        input logic [15:0] win, input logic [14:0] len);
    send_item(tcs_pkg::CmdSegment, fl, sq, ak, win, len, 1'b1, $urandom);
  endtask

  task automatic cmd_in(input logic [2:0] c, input logic [14:0] len);
    send_item(c, 6'($urandom), $urandom, $urandom, 16'($urandom), len, 1'($urandom),
              $urandom);
  endtask

  // Drop push, drain every result, then let the block settle.
  task automatic drain();
    push <= 1'b0;
    burst_left = 0;
    wait (pending_results.size() == 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [10:0] mss, input logic [15:0] cap,
                            input logic [15:0] iwin);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= tcs_pkg::CfgMss;
    cfg_data_i <= 16'(mss);
    @(posedge clk_i);
    cfg_idx_i <= tcs_pkg::CfgRxCap;
    cfg_data_i <= cap;
    @(posedge clk_i);
    cfg_idx_i <= tcs_pkg::CfgInitWin;
    cfg_data_i <= iwin;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_mss = mss;
    cfg_cap = cap;
    cfg_iwin = iwin;
    @(posedge clk_i);
  endtask

  task automatic open_session();
    send_item(tcs_pkg::CmdOpen, '0, '0, '0, '0, '0, 1'b1, $urandom);
    seg_in(tcs_pkg::FlSyn | tcs_pkg::FlAck, $urandom, snd_nxt, 16'hFFFF, '0);
  endtask

  task automatic test_closed_state();
    cmd_in(tcs_pkg::CmdSend, 15'd100);
    cmd_in(tcs_pkg::CmdConsume, 15'd10);
    cmd_in(tcs_pkg::CmdClose, '0);
    cmd_in(3'd5, '0);
    cmd_in(3'd6, '0);
    cmd_in(3'd7, '0);
    seg_in(tcs_pkg::FlSyn | tcs_pkg::FlAck, '1, '1, '1, '0);
  endtask

  task automatic test_handshake();
    send_item(tcs_pkg::CmdOpen, '0, '0, '0, '0, '0, 1'b1, 32'hFFFF_FFFF);
    cmd_in(tcs_pkg::CmdOpen, '0);
    send_item(tcs_pkg::CmdSegment, tcs_pkg::FlSyn | tcs_pkg::FlAck, 32'h1000, snd_nxt,
              16'hFFFF, '0, 1'b0, '0);
    seg_in(tcs_pkg::FlSyn | tcs_pkg::FlAck, 32'h1000, snd_nxt + 1, 16'hFFFF, '0);
    seg_in(tcs_pkg::FlRst, '0, '0, 16'hFFFF, '0);
    open_session();
  endtask

  task automatic test_data_path();
    seg_in(tcs_pkg::FlAck | tcs_pkg::FlPsh, rcv_nxt, 32'hFFFF_FFFF, 16'hFFFF, 15'd1000);
    seg_in(tcs_pkg::FlAck, rcv_nxt + 1, 32'd5, 16'hFFFF, 15'd100);
    seg_in(tcs_pkg::FlAck, rcv_nxt, '0, 16'hFFFF, 15'd16384);
    cmd_in(tcs_pkg::CmdConsume, 15'h7FFF);
    cmd_in(tcs_pkg::CmdConsume, 15'd1);
    cmd_in(tcs_pkg::CmdConsume, '0);
    seg_in(tcs_pkg::FlAck, '0, '0, 16'hFFFF, '0);
    cmd_in(tcs_pkg::CmdSend, 15'd16384);
    cmd_in(tcs_pkg::CmdSend, 15'd16385);
    cmd_in(tcs_pkg::CmdSend, '0);
    seg_in(tcs_pkg::FlAck, '0, '0, 16'd10, '0);
    cmd_in(tcs_pkg::CmdSend, 15'd11);
    cmd_in(tcs_pkg::CmdSend, 15'd10);
    seg_in(tcs_pkg::FlAck | tcs_pkg::FlFin, rcv_nxt, '0, 16'hFFFF, 15'd20);
    cmd_in(tcs_pkg::CmdClose, '0);
    seg_in(tcs_pkg::FlAck, '0, snd_nxt, 16'hFFFF, '0);
  endtask

  task automatic test_rst_established();
    open_session();
    seg_in(tcs_pkg::FlAck | tcs_pkg::FlRst, rcv_nxt, '0, 16'hFFFF, 15'd8);
  endtask

  task automatic random_step();
    int          pick;
    logic [5:0]  fl;
    logic [14:0] len;
    pick = $urandom_range(0, 99);
    len = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(1, 1500));
    if (pick < 6) begin
      send_item(3'($urandom_range(0, 7)), 6'($urandom), $urandom, $urandom, 16'($urandom),
                15'($urandom), 1'($urandom), $urandom);
      return;
    end
    case (conn_st)
      tcs_pkg::StClosed: open_session();
      tcs_pkg::StSynSent: begin
        if (pick < 80) begin
          seg_in(tcs_pkg::FlSyn | tcs_pkg::FlAck, $urandom, snd_nxt, 16'($urandom), '0);
        end else begin
          seg_in(tcs_pkg::FlRst, $urandom, $urandom, 16'($urandom), '0);
        end
      end
      tcs_pkg::StEstab: begin
        fl = (pick < 50) ? 6'($urandom) & ~(tcs_pkg::FlFin | tcs_pkg::FlRst)
                         : 6'($urandom) & ~tcs_pkg::FlRst;
        if (pick < 40) begin
          send_item(tcs_pkg::CmdSegment, fl, (pick < 35) ? rcv_nxt : 32'($urandom), $urandom,
                    ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'hFFFF, len,
                    ($urandom_range(0, 9) != 0), $urandom);
        end else if (pick < 62) begin
          cmd_in(tcs_pkg::CmdSend,
                 ($urandom_range(0, 15) == 0) ? 15'($urandom_range(8000, 16384)) : len);
        end else if (pick < 80) begin
          cmd_in(tcs_pkg::CmdConsume, len);
        end else if (pick < 93) begin
          seg_in(tcs_pkg::FlAck, rcv_nxt, $urandom, 16'hFFFF, '0);
        end else if (pick < 97) begin
          cmd_in(tcs_pkg::CmdClose, '0);
        end else begin
          seg_in(6'($urandom) | tcs_pkg::FlRst, $urandom, $urandom, 16'($urandom), '0);
        end
      end
      default: begin
        if (pick < 45) begin
          seg_in(tcs_pkg::FlAck | ((pick < 20) ? tcs_pkg::FlFin : 6'h0), $urandom, snd_nxt,
                 16'($urandom), '0);
        end else if (pick < 75) begin
          seg_in(tcs_pkg::FlFin, $urandom, $urandom, 16'($urandom), '0);
        end else begin
          cmd_in(tcs_pkg::CmdClose, '0);
        end
      end
    endcase
  endtask

  task automatic test_random(input int n);
    repeat (n) random_step();
  endtask

  task automatic test_backpressure();
    drain();
    if (conn_st != tcs_pkg::StEstab) open_session();
    hold_req = 1'b1;
    repeat (20) cmd_in(tcs_pkg::CmdConsume, 15'd1);
  endtask

  // Receiver: stall patterns, plus one long hold-off on request.
  initial begin
    int mode, span;
    pop = 1'b0;
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      repeat (span) begin
        case (mode)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom);
          2: pop <= ($urandom_range(0, 3) == 0);
          default: pop <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    tcs_pkg::result_t e;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $error("result with none expected");
        failed = 1'b1;
      end else begin
        e = pending_results.pop_front();
        if (emit_o !== e.emit) begin
          $error("emit exp %0d got %0d", e.emit, emit_o); failed = 1'b1;
        end
        if (tx_flags_o !== e.tx_flags) begin
          $error("tx_flags exp %0h got %0h", e.tx_flags, tx_flags_o); failed = 1'b1;
        end
        if (tx_seq_o !== e.tx_seq) begin
          $error("tx_seq exp %0h got %0h", e.tx_seq, tx_seq_o); failed = 1'b1;
        end
        if (tx_ack_o !== e.tx_ack) begin
          $error("tx_ack exp %0h got %0h", e.tx_ack, tx_ack_o); failed = 1'b1;
        end
        if (tx_window_o !== e.tx_window) begin
          $error("tx_window exp %0d got %0d", e.tx_window, tx_window_o); failed = 1'b1;
        end
        if (tx_length_o !== e.tx_length) begin
          $error("tx_length exp %0d got %0d", e.tx_length, tx_length_o); failed = 1'b1;
        end
        if (conn_state_o !== e.conn_state) begin
          $error("conn_state exp %0d got %0d", e.conn_state, conn_state_o); failed = 1'b1;
        end
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o); failed = 1'b1;
        end
        if (byte_count_o !== e.byte_count) begin
          $error("byte_count exp %0d got %0d", e.byte_count, byte_count_o); failed = 1'b1;
        end
        if (last_o !== e.last) begin
          $error("last exp %0d got %0d", e.last, last_o); failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > IdleLimit) begin
      $display("tcp_connection_state_machine: mismatch");
      $finish;
    end
  end

  initial begin
    failed = 1'b0;
    hold_req = 1'b0;
    burst_left = 0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    push = 1'b0;
    cmd_i = '0;
    seg_flags_i = '0;
    seg_seq_i = '0;
    seg_ack_i = '0;
    seg_window_i = '0;
    length_i = '0;
    checksum_ok_i = 1'b0;
    start_seq_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = tcs_pkg::CfgMss;
    cfg_data_i = '0;
    conn_st = tcs_pkg::StClosed;
    snd_nxt = '0; ack_out = '0; rcv_nxt = '0; top_ack = '0;
    rx_bytes = '0; lwin = '0; rwin = '0;
    cfg_mss = tcs_pkg::MssReset;
    cfg_cap = tcs_pkg::RxCapReset;
    cfg_iwin = tcs_pkg::InitWinReset;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_closed_state();
    test_handshake();
    test_data_path();
    test_rst_established();
    test_random(40);
    set_config(11'd0, 16'd1, 16'd0);
    test_random(30);
    set_config(11'h7FF, 16'hFFFF, 16'hFFFF);
    test_random(40);
    test_backpressure();
    set_config(11'd700, 16'd3000, 16'd5000);
    test_random(40);
    set_config(tcs_pkg::MssMin, 16'd8192, 16'd40000);
    test_random(30);

    drain();
    if (!failed) begin
      $display("tcp_connection_state_machine: match");
    end else begin
      $display("tcp_connection_state_machine: mismatch");
    end
    $finish;
  end

endmodule
